### design/b64enc_pkg.sv
// Package: shared types, constants and the alphabet map for the base64 encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

  // One closed group, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;   // real bytes in the group, 1..3
    logic       last;     // group closed by the final byte
    logic       url;      // alphabet in effect at close
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] map_char(input logic [5:0] idx, input logic url);
    logic [7:0] wide;
    logic [7:0] result;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      result = CHAR_UPPER_A + wide;
    end else if (idx < 6'd52) begin
      result = CHAR_LOWER_A + wide - 8'd26;
    end else if (idx < 6'd62) begin
      result = CHAR_DIGIT_0 + wide - 8'd52;
    end else if (idx == 6'd62) begin
      result = url ? CHAR_MINUS : CHAR_PLUS;
    end else begin
      result = url ? CHAR_UNDER : CHAR_SLASH;
    end
    return result;
  endfunction

endpackage

### design/b64enc_if.sv
// Stream interfaces: raw byte input and encoded character output.
`timescale 1ns / 1ps

interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_char, output run_end, output message_end,
                  input ready);
  modport sink (input valid, input out_char, input run_end, input message_end,
                output ready);
endinterface

### design/b64enc_front.sv
// Front end: takes bytes, gathers groups of up to three, pushes closed groups.
`timescale 1ns / 1ps

module b64enc_front import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          url_alphabet,
  b64enc_in_if.sink     in_stream,
  input  q_stat_t       q_stat,
  output logic          push,
  output group_t        push_data
);

  logic [1:0] phase;
  logic [7:0] p0;
  logic [7:0] p1;
  logic       accept;
  logic       closing;

  assign in_stream.ready = !q_stat.full;
  assign accept  = in_stream.valid && in_stream.ready;
  assign closing = in_stream.last_byte || (phase == 2'd2);
  assign push    = accept && closing;

  always_comb begin
    push_data.last   = in_stream.last_byte;
    push_data.url    = url_alphabet;
    push_data.nbytes = phase + 2'd1;
    case (phase)
      2'd0: begin
        push_data.b0 = in_stream.data_byte;
        push_data.b1 = 8'd0;
        push_data.b2 = 8'd0;
      end
      2'd1: begin
        push_data.b0 = p0;
        push_data.b1 = in_stream.data_byte;
        push_data.b2 = 8'd0;
      end
      default: begin
        push_data.b0 = p0;
        push_data.b1 = p1;
        push_data.b2 = in_stream.data_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (accept) begin
      phase <= closing ? 2'd0 : phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      if (phase == 2'd0) begin
        p0 <= in_stream.data_byte;
      end else begin
        p1 <= in_stream.data_byte;
      end
    end
  end

endmodule

### design/b64enc_queue.sv
// Two-entry group queue between front and back.
`timescale 1ns / 1ps

module b64enc_queue import b64enc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  group_t  push_data,
  input  logic    pop,
  output group_t  pop_data,
  output q_stat_t q_stat
);

  group_t     mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign pop_data     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

### design/b64enc_back.sv
// Back end: serializes one group into four characters through an output register.
`timescale 1ns / 1ps

module b64enc_back import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  q_stat_t       q_stat,
  input  group_t        pop_data,
  output logic          pop,
  b64enc_out_if.source  out_stream
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] k;
  logic       load;
  logic [5:0] idx;
  logic [7:0] char_next;

  assign load = cur_valid && (!out_stream.valid || out_stream.ready);
  assign pop  = !q_stat.empty && (!cur_valid || (load && k == 2'd3));

  always_comb begin
    case (k)
      2'd0:    idx = cur.b0[7:2];
      2'd1:    idx = {cur.b0[1:0], cur.b1[7:4]};
      2'd2:    idx = {cur.b1[3:0], cur.b2[7:6]};
      default: idx = cur.b2[5:0];
    endcase
    // characters past nbytes+1 are padding
    char_next = (k > cur.nbytes) ? PAD_CHAR : map_char(idx, cur.url);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid        <= 1'b0;
      k                <= 2'd0;
      out_stream.valid <= 1'b0;
    end else begin
      if (load) begin
        out_stream.valid <= 1'b1;
      end else if (out_stream.ready) begin
        out_stream.valid <= 1'b0;
      end
      // a pop restarts the character count for the new group
      if (pop) begin
        cur_valid <= 1'b1;
        k         <= 2'd0;
      end else if (load) begin
        k <= k + 2'd1;
        if (k == 2'd3) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_stream.out_char    <= char_next;
      out_stream.run_end     <= (k == 2'd3);
      out_stream.message_end <= (k == 2'd3) && cur.last;
    end
    if (pop) begin
      cur <= pop_data;
    end
  end

endmodule

### design/base64_stream_encoder_core.sv
// Top level: base64 stream encoder with front end, group queue and serializer.
//
//  channel     dir  payload                              handshake
//  in_stream   in   data_byte[7:0], last_byte            valid/ready
//  out_stream  out  out_char[7:0], run_end, message_end  valid/ready
//  cfg         in   cfg_wdata (url_alphabet)             cfg_we, no wait
//
// A byte is taken whenever the group queue has room; a closed group is
// spoken as four characters, one per cycle while the output is ready, by
// the serializer, so under sustained input the serializer sets the pace.
// A closed group goes through the queue, the cur register and the out register.
// Synchronous reset clears the pending count, the queue and the output valid.
// A stalled output holds its character; the front keeps taking bytes until
// the two-entry queue fills.
`timescale 1ns / 1ps

module base64_stream_encoder_core import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64enc_in_if.sink     in_stream,
  b64enc_out_if.source  out_stream
);

  logic    url_alphabet;
  logic    push;
  logic    pop;
  group_t  push_data;
  group_t  pop_data;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
    end else if (cfg_we) begin
      url_alphabet <= cfg_wdata;
    end
  end

  b64enc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .url_alphabet (url_alphabet),
    .in_stream    (in_stream),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  b64enc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_stream (out_stream)
  );

  // end of message only ever lands on the closing character of a run
  a_msg_end_on_run_end: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && out_stream.message_end |-> out_stream.run_end)
    else $error("message_end without run_end");

  // nothing is pushed into a full queue unless a pop frees an entry in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full || pop)
    else $error("group queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("group queue underflow");

  // output is quiet right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_stream.valid)
    else $error("output valid after reset");

endmodule

### test/b64enc_checker.sv
// Checker: watches both channels, predicts the encoded characters and compares them.
`timescale 1ns / 1ps

module b64enc_checker import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64enc_in_if          in_mon,
  b64enc_out_if         out_mon,
  output int            fail_count,
  output int            outstanding
);

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } enc_char_t;

  enc_char_t  char_q[$];
  enc_char_t  got;
  enc_char_t  want;
  logic [1:0] held_cnt;
  logic [7:0] held [2];
  logic       url_sel;
  int         fails;

  initial begin
    fails    = 0;
    held_cnt = '0;
    held     = '{8'h00, 8'h00};
    url_sel  = 1'b0;
  end

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s, input logic url);
    logic [7:0] v;
    v = {2'b00, s};
    if (s <= 6'd25) return CHAR_UPPER_A + v;
    if (s <= 6'd51) return CHAR_LOWER_A + (v - 8'd26);
    if (s <= 6'd61) return CHAR_DIGIT_0 + (v - 8'd52);
    if (s == 6'd62) return url ? CHAR_MINUS : CHAR_PLUS;
    return url ? CHAR_UNDER : CHAR_SLASH;
  endfunction

  // Hold bytes until a group closes, then queue its four characters.
  task automatic encode_byte(input logic [7:0] d, input logic l);
    logic [7:0] b0, b1, b2;
    logic [5:0] sx [4];
    int         nchar;
    enc_char_t  e;
    if (held_cnt < 2'd2 && !l) begin
      held[held_cnt[0]] = d;
      held_cnt = held_cnt + 2'd1;
      return;
    end
    case (held_cnt)
      2'd0: begin
        b0 = d;       b1 = 8'h00;   b2 = 8'h00;
      end
      2'd1: begin
        b0 = held[0]; b1 = d;       b2 = 8'h00;
      end
      default: begin
        b0 = held[0]; b1 = held[1]; b2 = d;
      end
    endcase
    sx[0] = b0[7:2];
    sx[1] = {b0[1:0], b1[7:4]};
    sx[2] = {b1[3:0], b2[7:6]};
    sx[3] = b2[5:0];
    // real bytes + 1 characters, the rest is padding
    nchar = int'(held_cnt) + 2;
    for (int k = 0; k < 4; k++) begin
      e.ch      = (k < nchar) ? sextet_to_ascii(sx[k], url_sel) : PAD_CHAR;
      e.run_end = (k == 3);
      e.msg_end = (k == 3) && l;
      char_q.push_back(e);
    end
    held_cnt = '0;
    held     = '{8'h00, 8'h00};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_q.delete();
      held_cnt = '0;
      held     = '{8'h00, 8'h00};
      url_sel  = 1'b0;
    end else begin
      if (cfg_we) url_sel = cfg_wdata;
      if (in_mon.valid && in_mon.ready) encode_byte(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        got.ch      = out_mon.out_char;
        got.run_end = out_mon.run_end;
        got.msg_end = out_mon.message_end;
        if (char_q.size() == 0) begin
          $error("unexpected output transaction: out_char %h", got.ch);
          fails++;
        end else begin
          want = char_q.pop_front();
          if (got.ch !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, got.ch);
            fails++;
          end
          if (got.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, got.run_end);
            fails++;
          end
          if (got.msg_end !== want.msg_end) begin
            $error("message_end: expected %b, got %b", want.msg_end, got.msg_end);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= char_q.size();
  end

endmodule

### test/tb.sv
// Testbench top: clock, reset, stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   outstanding;
  int   snd_idle;
  int   rcv_idle;
  int   stall_req = 0;
  int   cycles;
  int   sent;

  b64enc_in_if  in_if ();
  b64enc_out_if out_if ();

  base64_stream_encoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  b64enc_checker CHK (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** base64_stream_encoder_core: FAILED **");
    $finish;
  end

  // Receiver: random ready, plus a long hold-off on request.
  initial begin
    int hold;
    int stall_seen;
    hold       = 0;
    stall_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // valid stays high across back-to-back transactions; it drops only in a gap
  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_msg(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), close && (i == len - 1));
    end
  endtask

  // Drain all expected characters, then let the clock run on before returning.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_url(input logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int len;
    int goal;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    snd_idle        = 33;
    rcv_idle        = 62;
    sent            = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-byte and two-byte finals, full groups, both alphabets.
    write_url(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_url(1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hF8, 1'b1);
    // alphabet flipped while a group is still filling
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_url(1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_url(1'b1);
    send_byte(8'hFF, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle = 33;
          rcv_idle <= 62;
        end
        1: begin
          snd_idle = 62;
          rcv_idle <= 33;
        end
        default: begin
          snd_idle = 0;
          rcv_idle <= 0;
        end
      endcase
      if (mode == 2) begin
        // long receiver hold-off while the sender keeps pushing
        stall_req <= stall_req + 1;
        send_msg(30, 1'b1);
      end
      goal = sent + 60;
      while (sent < goal) begin
        if ($urandom_range(4) == 0) write_url(1'($urandom_range(1)));
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 10);
        // now and then leave the message open so it runs on into the next
        send_msg(len, $urandom_range(5) != 0);
      end
    end
    send_msg(1, 1'b1);
    write_url(1'b0);

    settle();
    if (fail_count == 0) begin
      $display("** base64_stream_encoder_core: PASSED **");
    end else begin
      $display("** base64_stream_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
